// File: sv/pwgf_pkg.sv
// Shared types, register indexes and widths for the pulse-width glitch filter.
// Depends on nothing; every other file imports it.
`default_nettype none

package pwgf_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned ThrCfgW  = 16;
  localparam int unsigned OffCfgW  = 48;

  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMode      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOffset    = 2'd2;

  typedef enum logic [1:0] {
    ModeBoth = 2'd0,
    ModeHigh = 2'd1,
    ModeLow  = 2'd2,
    ModeNone = 2'd3
  } filter_mode_e;

  function automatic logic mode_filters(filter_mode_e mode, logic level);
    logic res;
    case (mode)
      ModeBoth: res = 1'b1;
      ModeHigh: res = level;
      ModeLow:  res = ~level;
      default:  res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/pwgf_cfg_regs.sv
// Configuration register file for the pulse-width glitch filter.
// Depends on pwgf_pkg for register indexes, widths and the mode type.
`default_nettype none

module pwgf_cfg_regs
  import pwgf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic [ThrCfgW-1:0]       threshold_o,
  output filter_mode_e             mode_o,
  output logic [OffCfgW-1:0]       offset_o
);

  logic [ThrCfgW-1:0] threshold_q;
  filter_mode_e       mode_q;
  logic [OffCfgW-1:0] offset_q;
  logic               wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      mode_q      <= ModeBoth;
      offset_q    <= '0;
    end else if (wr_en) begin
      case (cfg_index_i)
        RegThreshold: threshold_q <= cfg_data_i[ThrCfgW-1:0];
        RegMode:      mode_q      <= filter_mode_e'(cfg_data_i[1:0]);
        RegOffset:    offset_q    <= cfg_data_i[OffCfgW-1:0];
        default:      ;
      endcase
    end
  end

  assign threshold_o = threshold_q;
  assign mode_o      = mode_q;
  assign offset_o    = offset_q;

endmodule

`default_nettype wire

// File: sv/pwgf_core.sv
// Input register, filter state and single-pass next-state logic of the glitch filter.
// Depends on pwgf_pkg for the mode type, the mode test and configuration widths.
`default_nettype none

module pwgf_core
  import pwgf_pkg::*;
#(
  parameter int unsigned POSITION_BITS  = 48,
  parameter int unsigned THRESHOLD_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     sample_bit_i,
  input  wire logic                     capture_end_i,
  input  wire logic [ThrCfgW-1:0]       threshold_i,
  input  wire filter_mode_e             mode_i,
  input  wire logic [OffCfgW-1:0]       offset_i,
  input  wire logic                     res_ready_i,
  output logic                          res_valid_o,
  output logic [POSITION_BITS-1:0]      res_start_o,
  output logic [POSITION_BITS-1:0]      res_end_o,
  output logic                          res_level_o
);

  localparam int unsigned LenW = THRESHOLD_BITS + 1;

  logic                     item_valid_q, item_valid_d;
  logic                     item_bit_q, item_last_q;
  logic                     accept, advance;

  logic                     started_q, started_d;
  logic                     level_q, level_d;
  logic                     in_dep_q, in_dep_d;
  logic [POSITION_BITS-1:0] dep_start_q, dep_start_d;
  logic [LenW-1:0]          dep_len_q, dep_len_d;
  logic [POSITION_BITS-1:0] spos_q, spos_d;

  logic [THRESHOLD_BITS-1:0] thr;
  logic [POSITION_BITS-1:0]  pos;
  logic [LenW-1:0]           len_inc;
  logic                      fill;
  logic [POSITION_BITS-1:0]  fill_start;
  logic [POSITION_BITS-1:0]  fill_end;

  assign accept       = in_valid_i & ~in_stall_o;
  assign advance      = item_valid_q & res_ready_i;
  assign in_stall_o   = item_valid_q & ~res_ready_i;
  assign item_valid_d = accept | (item_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_bit_q  <= sample_bit_i;
      item_last_q <= capture_end_i;
    end
  end

  assign thr     = THRESHOLD_BITS'(threshold_i);
  assign pos     = POSITION_BITS'(offset_i) + spos_q;
  assign len_inc = dep_len_q + LenW'(1);

  always_comb begin
    started_d   = started_q;
    level_d     = level_q;
    in_dep_d    = in_dep_q;
    dep_start_d = dep_start_q;
    dep_len_d   = dep_len_q;
    spos_d      = spos_q + POSITION_BITS'(1);
    fill        = 1'b0;
    fill_start  = dep_start_q;
    fill_end    = pos;

    if (!started_q) begin
      started_d = 1'b1;
      level_d   = item_bit_q;
      in_dep_d  = 1'b0;
    end else if (in_dep_q) begin
      if (item_bit_q == level_q) begin
        fill     = 1'b1;
        in_dep_d = 1'b0;
      end else begin
        dep_len_d = len_inc;
        if (len_inc > LenW'(thr)) begin
          level_d  = item_bit_q;
          in_dep_d = 1'b0;
        end
      end
    end else if (item_bit_q != level_q) begin
      if ((thr != '0) && mode_filters(mode_i, level_q)) begin
        in_dep_d    = 1'b1;
        dep_start_d = pos;
        dep_len_d   = LenW'(1);
      end else begin
        level_d = item_bit_q;
      end
    end

    if (item_last_q) begin
      if (in_dep_d) begin
        fill       = 1'b1;
        fill_start = dep_start_d;
        fill_end   = pos + POSITION_BITS'(1);
      end
      started_d   = 1'b0;
      level_d     = 1'b0;
      in_dep_d    = 1'b0;
      dep_start_d = '0;
      dep_len_d   = '0;
      spos_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      level_q     <= 1'b0;
      in_dep_q    <= 1'b0;
      dep_start_q <= '0;
      dep_len_q   <= '0;
      spos_q      <= '0;
    end else if (advance) begin
      started_q   <= started_d;
      level_q     <= level_d;
      in_dep_q    <= in_dep_d;
      dep_start_q <= dep_start_d;
      dep_len_q   <= dep_len_d;
      spos_q      <= spos_d;
    end
  end

  assign res_valid_o = advance & fill;
  assign res_start_o = fill_start;
  assign res_end_o   = fill_end;
  assign res_level_o = level_q;

endmodule

`default_nettype wire

// File: sv/pwgf_out_reg.sv
// Output register of the glitch filter, holding one fill range for the receiver.
// Depends on pwgf_pkg only through the common import convention.
`default_nettype none

module pwgf_out_reg
  import pwgf_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     res_valid_i,
  output logic                          res_ready_o,
  input  wire logic [POSITION_BITS-1:0] res_start_i,
  input  wire logic [POSITION_BITS-1:0] res_end_i,
  input  wire logic                     res_level_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [POSITION_BITS-1:0]      fill_start_o,
  output logic [POSITION_BITS-1:0]      fill_end_o,
  output logic                          fill_level_o
);

  logic                     valid_q, valid_d;
  logic [POSITION_BITS-1:0] start_q, end_q;
  logic                     level_q;
  logic                     load;

  assign res_ready_o = ~valid_q | ~out_stall_i;
  assign load        = res_valid_i & res_ready_o;
  assign valid_d     = load | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      start_q <= res_start_i;
      end_q   <= res_end_i;
      level_q <= res_level_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign fill_start_o = start_q;
  assign fill_end_o   = end_q;
  assign fill_level_o = level_q;

endmodule

`default_nettype wire

// File: sv/pulse_width_glitch_filter.sv
// Pulse-width glitch filter for one logic channel: top level.
// Instantiates pwgf_cfg_regs, pwgf_core and pwgf_out_reg; imports pwgf_pkg.
//
// Usage: one sample per input transaction on in_valid_i/in_stall_o, carrying
// sample_bit_i and capture_end_i (high on the last sample of a capture).
// Each fill range (fill_start_o, fill_end_o exclusive, fill_level_o) leaves
// as one transaction on out_valid_o/out_stall_i; most samples produce none.
// Registers are written on cfg_valid_i/cfg_ready_o (always ready) with
// cfg_index_i 0 threshold, 1 mode, 2 capture offset; write only when idle.
// Path: an accepted sample is held in the input register, evaluated there by
// the state logic, and its fill range then goes into the output register.
// Throughput: one sample per cycle while the output register is not stalled,
// set by the state update between the input and the output register.
// Stalls: the output register holds its range while out_stall_i is high; the
// input register then fills and in_stall_o rises, so nothing is dropped.
// Reset: registers, filter state and both stages clear at once; no clearing
// pass is needed and samples are taken from the first cycle after reset.
`default_nettype none

module pulse_width_glitch_filter
  import pwgf_pkg::*;
#(
  parameter int unsigned POSITION_BITS  = 48,
  parameter int unsigned THRESHOLD_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     sample_bit_i,
  input  wire logic                     capture_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [POSITION_BITS-1:0]      fill_start_o,
  output logic [POSITION_BITS-1:0]      fill_end_o,
  output logic                          fill_level_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [CfgDataW-1:0]      cfg_data_i
);

  logic [ThrCfgW-1:0]       threshold;
  filter_mode_e             mode;
  logic [OffCfgW-1:0]       offset;
  logic                     res_valid, res_ready, res_level;
  logic [POSITION_BITS-1:0] res_start, res_end;

  pwgf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .threshold_o (threshold),
    .mode_o      (mode),
    .offset_o    (offset)
  );

  pwgf_core #(
    .POSITION_BITS  (POSITION_BITS),
    .THRESHOLD_BITS (THRESHOLD_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_bit_i  (sample_bit_i),
    .capture_end_i (capture_end_i),
    .threshold_i   (threshold),
    .mode_i        (mode),
    .offset_i      (offset),
    .res_ready_i   (res_ready),
    .res_valid_o   (res_valid),
    .res_start_o   (res_start),
    .res_end_o     (res_end),
    .res_level_o   (res_level)
  );

  pwgf_out_reg #(
    .POSITION_BITS (POSITION_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_start_i  (res_start),
    .res_end_i    (res_end),
    .res_level_i  (res_level),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fill_start_o (fill_start_o),
    .fill_end_o   (fill_end_o),
    .fill_level_o (fill_level_o)
  );

endmodule

`default_nettype wire
